[hdl/tbcd_pkg.sv]
// tbcd_pkg: shared constants and helpers for the brightness command decoder
// holds prefix byte tables, outcome, phase and number stage codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tbcd_pkg;

   localparam int LEVEL_W   = 7;
   localparam int PHASE_W   = 2;
   localparam int OUTCOME_W = 3;
   localparam int COUNT_W   = 4;
   localparam int ACC_W     = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [COUNT_W-1:0] PREFIX_LEN = 4'd6;
   localparam logic [COUNT_W-1:0] TAIL_LAST  = 4'd8;
   localparam logic [COUNT_W-1:0] SET_MIN    = 4'd7;
   localparam logic [COUNT_W-1:0] SET_MAX    = 4'd9;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
   localparam logic [ACC_W-1:0]   ACC_MAX    = 10'd1023;
   localparam logic [ACC_W-1:0]   LEVEL_MAX  = 10'd100;

   localparam logic [LEVEL_W-1:0] FIRST_LEVEL_RST  = 7'd80;
   localparam logic [LEVEL_W-1:0] SECOND_LEVEL_RST = 7'd60;
   localparam logic [LEVEL_W-1:0] THIRD_LEVEL_RST  = 7'd40;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD_LEVEL  = 2'd2;

   // result outcome codes
   localparam logic [OUTCOME_W-1:0] OUTCOME_NONE     = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_OFF      = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_SET      = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_REJECTED = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUTCOME_ON       = 3'd4;

   // on-cycle phase codes
   localparam logic [PHASE_W-1:0] PHASE_NONE   = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd3;

   // tail number parser stages
   localparam logic [1:0] NUM_SKIP   = 2'd0;
   localparam logic [1:0] NUM_DIGITS = 2'd1;
   localparam logic [1:0] NUM_DONE   = 2'd2;

   typedef logic [7:0] byte_type;

   // utf-8 "off" command text
   function automatic byte_type off_byte(input logic [2:0] idx);
      byte_type b;
      case (idx)
         3'd0: b = 8'hE5;
         3'd1: b = 8'h85;
         3'd2: b = 8'hB3;
         3'd3: b = 8'hE7;
         3'd4: b = 8'h81;
         3'd5: b = 8'hAF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // utf-8 "brightness" command text
   function automatic byte_type set_byte(input logic [2:0] idx);
      byte_type b;
      case (idx)
         3'd0: b = 8'hE4;
         3'd1: b = 8'hBA;
         3'd2: b = 8'hAE;
         3'd3: b = 8'hE5;
         3'd4: b = 8'hBA;
         3'd5: b = 8'hA6;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // utf-8 "on" command text
   function automatic byte_type on_byte(input logic [2:0] idx);
      byte_type b;
      case (idx)
         3'd0: b = 8'hE5;
         3'd1: b = 8'hBC;
         3'd2: b = 8'h80;
         3'd3: b = 8'hE7;
         3'd4: b = 8'h81;
         3'd5: b = 8'hAF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic is_space(input byte_type b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic is_digit(input byte_type b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

endpackage

`default_nettype wire

[hdl/text_brightness_command_decoder.sv]
// text_brightness_command_decoder: byte-wise decoder for utf-8 lamp commands
// one module with a registered result stage
// depends on tbcd_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  rx_byte, frame_end
// rsp_      out        rsp_valid/rsp_ready  target_level, cycle_phase, outcome
// csr_      in         csr_we               csr_index, csr_wdata (7 bit levels)
//
// one byte per cycle while req_ready is high; each byte updates the frame state in the cycle it is taken
// a frame_end byte loads the result register, visible the next cycle
// req_ready drops only while a result waits and rsp_ready is low
// synchronous reset restores default levels, clears target, phase and frame
// bytes without frame_end are taken even while a result waits

module text_brightness_command_decoder
   import tbcd_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // byte input
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [7:0]            req_rx_byte,
   input  wire                   req_frame_end,
   // frame result
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [LEVEL_W-1:0]    rsp_target_level,
   output logic [PHASE_W-1:0]    rsp_cycle_phase,
   output logic [OUTCOME_W-1:0]  rsp_outcome,
   // level registers
   input  wire                   csr_we,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [LEVEL_W-1:0]    csr_wdata
);

   // configuration
   logic [LEVEL_W-1:0] first_level_ff, second_level_ff, third_level_ff;

   // lamp state
   logic [LEVEL_W-1:0] target_ff, target_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   // per-frame decode state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [2:0]         alive_ff, alive_in;
   logic [1:0]         stage_ff, stage_in;
   logic               neg_ff, neg_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic [PHASE_W-1:0]   rsp_phase_ff;
   logic [OUTCOME_W-1:0] rsp_outcome_ff, outcome_in;

   logic       accept;
   logic       last_accept;
   logic       in_prefix, in_tail, run_digit;
   logic [2:0] idx;
   logic [13:0] acc_sum;

   // a frame_end byte needs the result slot; other bytes go straight in
   assign req_ready   = !rsp_valid_ff || rsp_ready || !req_frame_end;
   assign accept      = req_valid && req_ready;
   assign last_accept = accept && req_frame_end;

   assign idx       = count_ff[2:0];
   assign in_prefix = count_ff < PREFIX_LEN;
   assign in_tail   = !in_prefix && (count_ff <= TAIL_LAST);

   // acc * 10 + digit, digits are 0x30..0x39 so the low nibble is the value
   assign acc_sum = ({4'b0, acc_ff} * 14'd10) + {10'b0, req_rx_byte[3:0]};

   // per-byte frame update: prefix match, atoi-style tail parse, count
   always_comb begin
      alive_in  = alive_ff;
      stage_in  = stage_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      run_digit = 1'b0;

      if (in_prefix) begin
         if (req_rx_byte != off_byte(idx)) alive_in[0] = 1'b0;
         if (req_rx_byte != set_byte(idx)) alive_in[1] = 1'b0;
         if (req_rx_byte != on_byte(idx))  alive_in[2] = 1'b0;
      end else if (in_tail) begin
         case (stage_ff)
            NUM_SKIP: begin
               if (is_space(req_rx_byte)) begin
                  stage_in = NUM_SKIP;
               end else if (req_rx_byte == 8'h2B || req_rx_byte == 8'h2D) begin
                  // one sign byte, then digits
                  neg_in   = (req_rx_byte == 8'h2D);
                  stage_in = NUM_DIGITS;
               end else begin
                  stage_in  = NUM_DIGITS;
                  run_digit = 1'b1;
               end
            end
            NUM_DIGITS: begin
               run_digit = 1'b1;
            end
            default: begin
               stage_in = stage_ff;
            end
         endcase

         if (run_digit) begin
            if (is_digit(req_rx_byte)) begin
               acc_in = (acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
            end else begin
               // any other byte ends the number
               stage_in = NUM_DONE;
            end
         end
      end

      count_in = (count_ff < COUNT_MAX) ? count_ff + 4'd1 : count_ff;
   end

   // end-of-frame decision; off beats set beats on
   always_comb begin
      target_in  = target_ff;
      phase_in   = phase_ff;
      outcome_in = OUTCOME_NONE;

      if (count_in >= PREFIX_LEN && alive_in[0]) begin
         target_in  = '0;
         phase_in   = PHASE_NONE;
         outcome_in = OUTCOME_OFF;
      end else if (count_in >= SET_MIN && count_in <= SET_MAX && alive_in[1]) begin
         // minus zero is still zero and passes
         if (acc_in == '0 || (!neg_in && acc_in <= LEVEL_MAX)) begin
            target_in  = acc_in[LEVEL_W-1:0];
            phase_in   = PHASE_NONE;
            outcome_in = OUTCOME_SET;
         end else begin
            outcome_in = OUTCOME_REJECTED;
         end
      end else if (count_in >= PREFIX_LEN && alive_in[2]) begin
         case (phase_ff)
            PHASE_FIRST: begin
               target_in = second_level_ff;
               phase_in  = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               target_in = third_level_ff;
               phase_in  = PHASE_THIRD;
            end
            default: begin
               target_in = first_level_ff;
               phase_in  = PHASE_FIRST;
            end
         endcase
         outcome_in = OUTCOME_ON;
      end
   end

   assign rsp_valid_in = last_accept || (rsp_valid_ff && !rsp_ready);

   // level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_level_ff  <= FIRST_LEVEL_RST;
         second_level_ff <= SECOND_LEVEL_RST;
         third_level_ff  <= THIRD_LEVEL_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_LEVEL:  first_level_ff  <= csr_wdata;
            CSR_SECOND_LEVEL: second_level_ff <= csr_wdata;
            CSR_THIRD_LEVEL:  third_level_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame and lamp state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         phase_ff     <= PHASE_NONE;
         count_ff     <= '0;
         alive_ff     <= 3'b111;
         stage_ff     <= NUM_SKIP;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (last_accept) begin
            // commit the lamp state and start a fresh frame
            target_ff <= target_in;
            phase_ff  <= phase_in;
            count_ff  <= '0;
            alive_ff  <= 3'b111;
            stage_ff  <= NUM_SKIP;
            neg_ff    <= 1'b0;
            acc_ff    <= '0;
         end else if (accept) begin
            count_ff <= count_in;
            alive_ff <= alive_in;
            stage_ff <= stage_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (last_accept) begin
         rsp_level_ff   <= target_in;
         rsp_phase_ff   <= phase_in;
         rsp_outcome_ff <= outcome_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_level = rsp_level_ff;
   assign rsp_cycle_phase  = rsp_phase_ff;
   assign rsp_outcome      = rsp_outcome_ff;

endmodule

`default_nettype wire
